[sv/socm_pkg.sv]
`default_nettype none
package socm_pkg;

    localparam int WINDOW_CHUNKS = 16;
    localparam int HALF          = WINDOW_CHUNKS / 2;
    localparam int CELLS         = WINDOW_CHUNKS * WINDOW_CHUNKS;
    localparam int IDX_W         = $clog2(CELLS);
    localparam int RC_W          = $clog2(WINDOW_CHUNKS);
    localparam int PHYS_W        = 10;
    localparam int MAX_RAY       = 127;
    localparam int NOTE_DEPTH    = 31;
    localparam int NOTE_AW       = $clog2(NOTE_DEPTH);
    localparam int NOTE_W        = 80;
    localparam int COORD_W       = 12;
    localparam int ERR_W         = 14;
    localparam int SQRT_STEPS    = 28;
    localparam int DIV_STEPS     = 39;
    localparam int STEP_W        = $clog2(DIV_STEPS);
    localparam int RATIO_W       = 17;

    localparam logic [2:0] FN_RD_PIX = 3'd0;
    localparam logic [2:0] FN_WR_PIX = 3'd1;
    localparam logic [2:0] FN_RD_CHK = 3'd2;
    localparam logic [2:0] FN_WR_CHK = 3'd3;
    localparam logic [2:0] FN_RAY    = 3'd4;
    localparam logic [2:0] FN_CLEAR  = 3'd5;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic [6:0]                lim;
    } t_clip_req;

    typedef struct packed {
        logic                      done;
        logic                      in_lim;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } t_clip_rsp;

endpackage
`default_nettype wire

[sv/socm_ifs.sv]
`default_nettype none
interface socm_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic signed [10:0] target_x;
    logic signed [10:0] target_y;
    logic               pixel_bit;
    logic [63:0]        chunk_word;
    logic [6:0]         ray_limit;

    modport source (output valid, func, pos_x, pos_y, target_x, target_y, pixel_bit,
                    chunk_word, ray_limit, input ready);
    modport sink (input valid, func, pos_x, pos_y, target_x, target_y, pixel_bit,
                  chunk_word, ray_limit, output ready);
endinterface

interface socm_out_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic signed [7:0] note_chunk_x;
    logic signed [7:0] note_chunk_y;
    logic [63:0]       note_data;
    logic              read_bit;
    logic signed [7:0] center_x;
    logic signed [7:0] center_y;
    logic              last;

    modport source (output valid, kind, note_chunk_x, note_chunk_y, note_data, read_bit,
                    center_x, center_y, last, input ready);
    modport sink (input valid, kind, note_chunk_x, note_chunk_y, note_data, read_bit,
                  center_x, center_y, last, output ready);
endinterface
`default_nettype wire

[sv/socm_ram.sv]
`default_nettype none
module socm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[sv/socm_clip.sv]
`default_nettype none
module socm_clip
    import socm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_clip_req i_req,
    output t_clip_rsp o_rsp
);

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_SQ   = 7'b0000010,
        C_SUM  = 7'b0000100,
        C_SQRT = 7'b0001000,
        C_DIV  = 7'b0010000,
        C_MUL  = 7'b0100000,
        C_FIN  = 7'b1000000
    } t_cstate;

    t_cstate                   r_state;
    logic signed [COORD_W-1:0] r_dx, r_dy;
    logic [10:0]               r_adx, r_ady;
    logic [6:0]                r_lim;
    logic [21:0]               r_sqx, r_sqy;
    logic [13:0]               r_l2;
    logic [55:0]               r_rad;
    logic [28:0]               r_rem;
    logic [27:0]               r_root;
    logic [38:0]               r_num;
    logic [27:0]               r_drem;
    logic [RATIO_W-1:0]        r_q;
    logic [STEP_W-1:0]         r_cnt;
    logic [27:0]               r_mx, r_my;
    logic                      r_done, r_inside;
    logic signed [COORD_W-1:0] r_ex, r_ey;

    logic [22:0] d2;
    logic [30:0] sq_rem2, sq_trial;
    logic [28:0] dv_rem2;
    logic [COORD_W-1:0] mag_x, mag_y;

    always_comb begin
        d2       = 23'(r_sqx) + 23'(r_sqy);
        sq_rem2  = {r_rem, r_rad[55:54]};
        sq_trial = {1'b0, r_root, 2'b01};
        dv_rem2  = {r_drem, r_num[38]};
        mag_x    = r_mx[27:16];
        mag_y    = r_my[27:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                C_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_dx    <= i_req.dx;
                        r_dy    <= i_req.dy;
                        r_adx   <= 11'(i_req.dx < 0 ? -i_req.dx : i_req.dx);
                        r_ady   <= 11'(i_req.dy < 0 ? -i_req.dy : i_req.dy);
                        r_lim   <= (int'(i_req.lim) > MAX_RAY) ? 7'(MAX_RAY) : i_req.lim;
                        r_state <= C_SQ;
                    end
                end
                C_SQ: begin
                    r_sqx   <= r_adx * r_adx;
                    r_sqy   <= r_ady * r_ady;
                    r_l2    <= r_lim * r_lim;
                    r_state <= C_SUM;
                end
                C_SUM: begin
                    if (d2 <= 23'(r_l2)) begin
                        r_inside <= 1'b1;
                        r_ex     <= r_dx;
                        r_ey     <= r_dy;
                        r_done   <= 1'b1;
                        r_state  <= C_IDLE;
                    end else begin
                        r_inside <= 1'b0;
                        r_rad    <= {1'b0, d2, 32'd0};
                        r_rem    <= '0;
                        r_root   <= '0;
                        r_cnt    <= '0;
                        r_state  <= C_SQRT;
                    end
                end
                C_SQRT: begin
                    // two radicand bits per step, one root bit out
                    if (sq_rem2 >= sq_trial) begin
                        r_rem  <= 29'(sq_rem2 - sq_trial);
                        r_root <= {r_root[26:0], 1'b1};
                    end else begin
                        r_rem  <= 29'(sq_rem2);
                        r_root <= {r_root[26:0], 1'b0};
                    end
                    r_rad <= {r_rad[53:0], 2'b00};
                    if (r_cnt == STEP_W'(SQRT_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_num   <= {r_lim, 32'd0};
                        r_drem  <= '0;
                        r_q     <= '0;
                        r_state <= C_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                C_DIV: begin
                    // restoring divide, one quotient bit per step
                    if (dv_rem2 >= 29'(r_root)) begin
                        r_drem <= 28'(dv_rem2 - 29'(r_root));
                        r_q    <= {r_q[RATIO_W-2:0], 1'b1};
                    end else begin
                        r_drem <= 28'(dv_rem2);
                        r_q    <= {r_q[RATIO_W-2:0], 1'b0};
                    end
                    r_num <= {r_num[37:0], 1'b0};
                    if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= C_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                C_MUL: begin
                    r_mx    <= 28'(r_adx) * 28'(r_q);
                    r_my    <= 28'(r_ady) * 28'(r_q);
                    r_state <= C_FIN;
                end
                C_FIN: begin
                    r_ex    <= (r_dx < 0) ? -signed'(mag_x) : signed'(mag_x);
                    r_ey    <= (r_dy < 0) ? -signed'(mag_y) : signed'(mag_y);
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.in_lim = r_inside;
    assign o_rsp.ex     = r_ex;
    assign o_rsp.ey     = r_ey;

endmodule
`default_nettype wire

[sv/scrolling_occupancy_chunk_map_core.sv]
// channel   dir  handshake       payload
// i_in      in   valid / ready   func, pos_x/y, target_x/y, pixel_bit, chunk_word, ray_limit
// o_out     out  valid / ready   kind, note_chunk_x/y, note_data, read_bit, center_x/y, last
//
// one transaction at a time; ready is high only while the sequencer is idle.
// pixel ops pass through locate, map and apply, chunk ops through map and apply, and
// each notification is then unloaded on the output; a scroll adds a copy sweep over all
// WINDOW_CHUNKS*WINDOW_CHUNKS entries, but a scroll past the whole window needs no sweep.
// a clipped ray first runs clip setup (sqrt and divide, one bit a step), an unclipped one
// skips them, then each pixel of the line goes through the chunk memory port.
// reset clears the per-chunk valid bits at once, no clearing pass.
// output stalls hold the sequencer while results are unloaded.
`default_nettype none
module scrolling_occupancy_chunk_map_core
    import socm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    socm_in_if.sink   i_in,
    socm_out_if.source o_out
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_LOC   = 12'b000000000010,
        S_MAP   = 12'b000000000100,
        S_SCRL  = 12'b000000001000,
        S_APPLY = 12'b000000010000,
        S_CLIP  = 12'b000000100000,
        S_CLIPW = 12'b000001000000,
        S_BINIT = 12'b000010000000,
        S_RSTEP = 12'b000100000000,
        S_DRAIN = 12'b001000000000,
        S_DLD   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    localparam logic signed [PHYS_W-1:0] P_WIN  = PHYS_W'(WINDOW_CHUNKS);
    localparam logic signed [PHYS_W-1:0] P_HALF = PHYS_W'(HALF);

    t_state                    r_state;
    logic [2:0]                r_func;
    logic signed [COORD_W-1:0] r_px, r_py, r_tx, r_ty, r_x1, r_y1;
    logic                      r_pv;
    logic [63:0]               r_word_in;
    logic [6:0]                r_lim;
    logic [7:0]                r_cx, r_cy;
    logic [5:0]                r_bit;
    logic [IDX_W-1:0]          r_idx;
    logic [7:0]                r_center_x, r_center_y;
    logic [7:0]                r_pend_x, r_pend_y;
    logic [63:0]               r_pend_w;
    logic [CELLS-1:0]          r_valid;
    logic                      r_vq;
    logic signed [ERR_W-1:0]   r_bdx, r_bdy, r_err;
    logic                      r_stx, r_sty, r_inside, r_final;
    logic signed [PHYS_W-1:0]  r_sx, r_sy;
    logic                      r_desc, r_pw, r_pin, r_issue_end;
    logic [RC_W-1:0]           r_row, r_col;
    logic [IDX_W-1:0]          r_pdst;
    logic [NOTE_AW-1:0]        r_nn, r_dk;
    logic [63:0]               r_data;
    logic                      r_rbit;
    logic                      r_ovalid, r_okind, r_obit, r_olast;
    logic [7:0]                r_ox, r_oy, r_ocx, r_ocy;
    logic [63:0]               r_odata;

    // store and notification memories
    logic                   st_we, st_re;
    logic [IDX_W-1:0]       st_waddr, st_raddr;
    logic [63:0]            st_wdata, st_rdata;
    logic                   nt_we, nt_re;
    logic [NOTE_AW-1:0]     nt_raddr;
    logic [NOTE_W-1:0]      nt_wdata, nt_rdata;

    t_clip_req clip_req;
    t_clip_rsp clip_rsp;

    // locate, map, sweep, apply, step signals
    logic signed [COORD_W-1:0] lc_xs, lc_ys, lc_ym1;
    logic [7:0]                lc_cx, lc_cy;
    logic [2:0]                lc_ly;
    logic [7:0]                mp_dx, mp_dy;
    logic signed [PHYS_W-1:0]  mp_px, mp_py, mp_sx, mp_sy;
    logic                      mp_move, mp_far;
    logic [IDX_W-1:0]          mp_idx;
    logic signed [PHYS_W-1:0]  sw_srow, sw_scol;
    logic                      sw_in, sw_last;
    logic [IDX_W-1:0]          sw_src, sw_dst;
    logic [63:0]               ap_word, ap_new;
    logic                      ap_flip, ap_note;
    logic signed [ERR_W-1:0]   bi_dx, bi_dy, rs_e2;
    logic                      out_free;

    assign out_free = !r_ovalid || o_out.ready;

    always_comb begin
        lc_xs  = r_px >>> 3;
        lc_ys  = r_py >>> 3;
        lc_ym1 = r_py - COORD_W'(1);
        lc_cx  = lc_xs[7:0];
        if (r_py > 0) begin
            lc_cy = lc_ys[7:0] + 8'd1;
            lc_ly = ~lc_ym1[2:0];
        end else begin
            lc_cy = lc_ys[7:0];
            lc_ly = r_py[2:0];
        end
    end

    always_comb begin
        mp_dx = r_cx - r_center_x;
        mp_dy = r_cy - r_center_y;
        mp_px = PHYS_W'(signed'(mp_dx)) + P_HALF;
        mp_py = PHYS_W'(signed'(mp_dy)) + P_HALF;
        if (mp_px < 0) begin
            mp_sx = mp_px;
        end else if (mp_px >= P_WIN) begin
            mp_sx = mp_px - P_WIN + PHYS_W'(1);
        end else begin
            mp_sx = '0;
        end
        if (mp_py < 0) begin
            mp_sy = mp_py;
        end else if (mp_py >= P_WIN) begin
            mp_sy = mp_py - P_WIN + PHYS_W'(1);
        end else begin
            mp_sy = '0;
        end
        mp_move = (mp_sx != 0) || (mp_sy != 0);
        mp_far  = (mp_sx >= P_WIN) || (mp_sx <= -P_WIN) ||
                  (mp_sy >= P_WIN) || (mp_sy <= -P_WIN);
        mp_idx  = IDX_W'(mp_py[RC_W-1:0]) * IDX_W'(WINDOW_CHUNKS) + IDX_W'(mp_px[RC_W-1:0]);
    end

    always_comb begin
        sw_srow = r_sy + signed'(PHYS_W'(r_row));
        sw_scol = r_sx + signed'(PHYS_W'(r_col));
        sw_in   = (sw_srow >= 0) && (sw_srow < P_WIN) && (sw_scol >= 0) && (sw_scol < P_WIN);
        sw_src  = IDX_W'(sw_srow[RC_W-1:0]) * IDX_W'(WINDOW_CHUNKS)
                  + IDX_W'(sw_scol[RC_W-1:0]);
        sw_dst  = IDX_W'(r_row) * IDX_W'(WINDOW_CHUNKS) + IDX_W'(r_col);
        if (r_desc) begin
            sw_last = (r_row == '0) && (r_col == '0);
        end else begin
            sw_last = (r_row == RC_W'(WINDOW_CHUNKS - 1)) && (r_col == RC_W'(WINDOW_CHUNKS - 1));
        end
    end

    always_comb begin
        ap_word = r_vq ? st_rdata : 64'd0;
        ap_new  = ap_word ^ (64'd1 << r_bit);
        ap_flip = ap_word[r_bit] != r_pv;
        ap_note = (r_cx != r_pend_x) || (r_cy != r_pend_y);
        bi_dx   = ERR_W'(r_x1) - ERR_W'(r_px);
        bi_dy   = ERR_W'(r_y1) - ERR_W'(r_py);
        rs_e2   = r_err <<< 1;
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_idx;
        st_wdata = ap_new;
        st_re    = 1'b0;
        st_raddr = mp_idx;
        nt_we    = 1'b0;
        nt_wdata = {r_pend_x, r_pend_y, r_pend_w};
        nt_re    = 1'b0;
        nt_raddr = r_dk;
        case (r_state)
            S_MAP: begin
                st_re = !mp_move;
            end
            S_SCRL: begin
                st_we    = r_pw;
                st_waddr = r_pdst;
                st_wdata = st_rdata;
                st_re    = !r_issue_end;
                st_raddr = sw_src;
            end
            S_APPLY: begin
                case (r_func)
                    FN_WR_PIX, FN_RAY: begin
                        st_we = ap_flip;
                        nt_we = ap_flip && ap_note && (r_nn < NOTE_AW'(NOTE_DEPTH));
                    end
                    FN_WR_CHK: begin
                        st_we    = ap_word != r_word_in;
                        st_wdata = r_word_in;
                        nt_we    = (ap_word != r_word_in) && (r_nn < NOTE_AW'(NOTE_DEPTH));
                        nt_wdata = {r_cx, r_cy, r_word_in};
                    end
                    default: ;
                endcase
            end
            S_DRAIN: begin
                nt_re = (r_dk != r_nn) && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_center_x <= '0;
            r_center_y <= '0;
            r_pend_x   <= '0;
            r_pend_y   <= '0;
            r_pend_w   <= '0;
            r_ovalid   <= 1'b0;
            r_nn       <= '0;
            r_dk       <= '0;
        end else begin
            if (o_out.ready && (r_state != S_DLD) && !((r_state == S_DONE) && out_free)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func    <= i_in.func;
                        r_px      <= COORD_W'(i_in.pos_x);
                        r_py      <= COORD_W'(i_in.pos_y);
                        r_tx      <= COORD_W'(i_in.target_x);
                        r_ty      <= COORD_W'(i_in.target_y);
                        r_pv      <= (i_in.func == FN_WR_PIX) ? i_in.pixel_bit : 1'b0;
                        r_word_in <= i_in.chunk_word;
                        r_lim     <= i_in.ray_limit;
                        r_cx      <= i_in.pos_x[7:0];
                        r_cy      <= i_in.pos_y[7:0];
                        r_final   <= 1'b0;
                        r_nn      <= '0;
                        r_dk      <= '0;
                        r_data    <= '0;
                        r_rbit    <= 1'b0;
                        case (i_in.func)
                            FN_RD_PIX, FN_WR_PIX: r_state <= S_LOC;
                            FN_RD_CHK, FN_WR_CHK: r_state <= S_MAP;
                            FN_RAY:               r_state <= S_CLIP;
                            FN_CLEAR: begin
                                r_valid    <= '0;
                                r_center_x <= '0;
                                r_center_y <= '0;
                                r_pend_x   <= '0;
                                r_pend_y   <= '0;
                                r_pend_w   <= '0;
                                r_state    <= S_DRAIN;
                            end
                            default: r_state <= S_DRAIN;
                        endcase
                    end
                end
                S_LOC: begin
                    r_cx    <= lc_cx;
                    r_cy    <= lc_cy;
                    r_bit   <= {lc_ly, r_px[2:0]};
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    if (mp_move) begin
                        r_center_x <= r_center_x + mp_sx[7:0];
                        r_center_y <= r_center_y + mp_sy[7:0];
                        if (mp_far) begin
                            r_valid <= '0;
                        end else begin
                            r_sx        <= mp_sx;
                            r_sy        <= mp_sy;
                            r_desc      <= (mp_sy < 0) || ((mp_sy == 0) && (mp_sx < 0));
                            r_row       <= (mp_sy < 0) || ((mp_sy == 0) && (mp_sx < 0))
                                           ? RC_W'(WINDOW_CHUNKS - 1) : '0;
                            r_col       <= (mp_sy < 0) || ((mp_sy == 0) && (mp_sx < 0))
                                           ? RC_W'(WINDOW_CHUNKS - 1) : '0;
                            r_pw        <= 1'b0;
                            r_issue_end <= 1'b0;
                            r_state     <= S_SCRL;
                        end
                    end else begin
                        r_idx   <= mp_idx;
                        r_vq    <= r_valid[mp_idx];
                        r_state <= S_APPLY;
                    end
                end
                S_SCRL: begin
                    // read the source one cycle, write the destination the next
                    if (r_pw) begin
                        r_valid[r_pdst] <= r_pin;
                    end
                    if (!r_issue_end) begin
                        r_pw   <= 1'b1;
                        r_pdst <= sw_dst;
                        r_pin  <= sw_in && r_valid[sw_src];
                        if (sw_last) begin
                            r_issue_end <= 1'b1;
                        end else if (r_desc) begin
                            if (r_col == '0) begin
                                r_col <= RC_W'(WINDOW_CHUNKS - 1);
                                r_row <= r_row - 1'b1;
                            end else begin
                                r_col <= r_col - 1'b1;
                            end
                        end else begin
                            if (r_col == RC_W'(WINDOW_CHUNKS - 1)) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end else begin
                        r_pw <= 1'b0;
                        if (!r_pw) begin
                            r_state <= S_MAP;
                        end
                    end
                end
                S_APPLY: begin
                    r_state <= (r_func == FN_RAY) ? S_RSTEP : S_DRAIN;
                    case (r_func)
                        FN_RD_PIX: r_rbit <= ap_word[r_bit];
                        FN_RD_CHK: r_data <= ap_word;
                        FN_WR_PIX, FN_RAY: begin
                            if (ap_flip) begin
                                r_valid[r_idx] <= 1'b1;
                                if (ap_note && (r_nn < NOTE_AW'(NOTE_DEPTH))) begin
                                    r_nn <= r_nn + 1'b1;
                                end
                                r_pend_x <= r_cx;
                                r_pend_y <= r_cy;
                                r_pend_w <= ap_new;
                            end
                        end
                        FN_WR_CHK: begin
                            if (ap_word != r_word_in) begin
                                r_valid[r_idx] <= 1'b1;
                                if (r_nn < NOTE_AW'(NOTE_DEPTH)) begin
                                    r_nn <= r_nn + 1'b1;
                                end
                                r_pend_x <= r_cx;
                                r_pend_y <= r_cy;
                                r_pend_w <= r_word_in;
                            end
                        end
                        default: ;
                    endcase
                end
                S_CLIP: begin
                    r_state <= S_CLIPW;
                end
                S_CLIPW: begin
                    if (clip_rsp.done) begin
                        r_x1     <= r_px + clip_rsp.ex;
                        r_y1     <= r_py + clip_rsp.ey;
                        r_inside <= clip_rsp.in_lim;
                        r_state  <= S_BINIT;
                    end
                end
                S_BINIT: begin
                    r_bdx   <= (bi_dx < 0) ? -bi_dx : bi_dx;
                    r_bdy   <= (bi_dy < 0) ? bi_dy : -bi_dy;
                    r_err   <= ((bi_dx < 0) ? -bi_dx : bi_dx) + ((bi_dy < 0) ? bi_dy : -bi_dy);
                    r_stx   <= r_px < r_x1;
                    r_sty   <= r_py < r_y1;
                    r_state <= S_LOC;
                end
                S_RSTEP: begin
                    if (r_final) begin
                        r_state <= S_DRAIN;
                    end else if ((r_px == r_x1) && (r_py == r_y1)) begin
                        if (r_inside) begin
                            // obstacle lies within the limit: mark it
                            r_final <= 1'b1;
                            r_px    <= r_tx;
                            r_py    <= r_ty;
                            r_pv    <= 1'b1;
                            r_state <= S_LOC;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_err <= r_err + ((rs_e2 >= r_bdy) ? r_bdy : ERR_W'(0))
                                       + ((rs_e2 <= r_bdx) ? r_bdx : ERR_W'(0));
                        if (rs_e2 >= r_bdy) begin
                            r_px <= r_stx ? r_px + COORD_W'(1) : r_px - COORD_W'(1);
                        end
                        if (rs_e2 <= r_bdx) begin
                            r_py <= r_sty ? r_py + COORD_W'(1) : r_py - COORD_W'(1);
                        end
                        r_state <= S_LOC;
                    end
                end
                S_DRAIN: begin
                    if (r_dk == r_nn) begin
                        r_state <= S_DONE;
                    end else if (out_free) begin
                        r_state <= S_DLD;
                    end
                end
                S_DLD: begin
                    r_ovalid <= 1'b1;
                    r_okind  <= KIND_NOTE;
                    r_ox     <= nt_rdata[79:72];
                    r_oy     <= nt_rdata[71:64];
                    r_odata  <= nt_rdata[63:0];
                    r_obit   <= 1'b0;
                    r_ocx    <= r_center_x;
                    r_ocy    <= r_center_y;
                    r_olast  <= 1'b0;
                    r_dk     <= r_dk + 1'b1;
                    r_state  <= S_DRAIN;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_DONE;
                        r_ox     <= '0;
                        r_oy     <= '0;
                        r_odata  <= r_data;
                        r_obit   <= r_rbit;
                        r_ocx    <= r_center_x;
                        r_ocy    <= r_center_y;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign clip_req.start = (r_state == S_CLIP);
    assign clip_req.dx    = r_tx - r_px;
    assign clip_req.dy    = r_ty - r_py;
    assign clip_req.lim   = r_lim;

    socm_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (clip_req),
        .o_rsp   (clip_rsp)
    );

    socm_ram #(.WIDTH(64), .DEPTH(CELLS)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    socm_ram #(.WIDTH(NOTE_W), .DEPTH(NOTE_DEPTH)) u_notes (
        .i_clk   (i_clk),
        .i_we    (nt_we),
        .i_waddr (r_nn),
        .i_wdata (nt_wdata),
        .i_re    (nt_re),
        .i_raddr (nt_raddr),
        .o_rdata (nt_rdata)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.kind         = r_okind;
    assign o_out.note_chunk_x = r_ox;
    assign o_out.note_chunk_y = r_oy;
    assign o_out.note_data    = r_odata;
    assign o_out.read_bit     = r_obit;
    assign o_out.center_x     = r_ocx;
    assign o_out.center_y     = r_ocy;
    assign o_out.last         = r_olast;

    // a finished sweep leaves the chunk inside the window
    a_scroll_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP && $past(r_state == S_SCRL)) |-> !mp_move)
        else $error("chunk still outside window after scroll");

    // the sweep never reads an entry it is writing in the same cycle
    a_sweep_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCRL && r_pw && !r_issue_end && sw_in) |-> (sw_src != r_pdst))
        else $error("scroll sweep read and write collide");

    // clip results arrive only while the sequencer waits for them
    a_clip_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clip_rsp.done |-> (r_state == S_CLIPW))
        else $error("clip result outside wait state");

endmodule
`default_nettype wire

[verif/scrolling_occupancy_chunk_map_core_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module scrolling_occupancy_chunk_map_core_tb;
    import socm_pkg::*;

    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;
    localparam int         MAX_NOTES = 31;

    typedef struct {
        logic [2:0]         func;
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic signed [10:0] target_x;
        logic signed [10:0] target_y;
        logic               pixel_bit;
        logic [63:0]        chunk_word;
        logic [6:0]         ray_limit;
        bit                 drain;
    } map_op_t;

    typedef struct {
        logic              kind;
        logic signed [7:0] chunk_x;
        logic signed [7:0] chunk_y;
        logic [63:0]       data;
        logic              read_bit;
        logic signed [7:0] center_x;
        logic signed [7:0] center_y;
        logic              last;
    } map_rsp_t;

    logic i_clk;
    logic i_rst_n;

    socm_in_if  in_bus();
    socm_out_if out_bus();

    scrolling_occupancy_chunk_map_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    map_op_t  op_queue[$];
    map_rsp_t rsp_queue[$];
    int       err_cnt;

    // shadow copy of the map
    logic [63:0] sh_store[CELLS];
    int          sh_cx, sh_cy;
    int          pend_x, pend_y;
    logic [63:0] pend_word;
    int          note_x[$], note_y[$];
    logic [63:0] note_w[$];

    function automatic int wrap8(input int v);
        logic signed [7:0] t;
        t = v[7:0];
        return int'(t);
    endfunction

    function automatic int fdiv8(input int a);
        return a >= 0 ? a / 8 : -((7 - a) / 8);
    endfunction

    function automatic int mod8(input int a);
        return a - 8 * fdiv8(a);
    endfunction

    function automatic int axis_shift(input int p);
        if (p < 0) return p;
        if (p >= WINDOW_CHUNKS) return p - WINDOW_CHUNKS + 1;
        return 0;
    endfunction

    function automatic void push_note(input int x, input int y, input logic [63:0] w);
        if (note_x.size() < MAX_NOTES) begin
            note_x.push_back(x);
            note_y.push_back(y);
            note_w.push_back(w);
        end
    endfunction

    function automatic int bring_in(input int cx, input int cy);
        logic [63:0] tmp[CELLS];
        int px, py, sx, sy, orow, ocol;
        px = wrap8(cx - sh_cx) + HALF;
        py = wrap8(cy - sh_cy) + HALF;
        sx = axis_shift(px);
        sy = axis_shift(py);
        if (sx != 0 || sy != 0) begin
            for (int r = 0; r < WINDOW_CHUNKS; r++) begin
                for (int c = 0; c < WINDOW_CHUNKS; c++) begin
                    orow = r + sy;
                    ocol = c + sx;
                    if (orow >= 0 && orow < WINDOW_CHUNKS && ocol >= 0 && ocol < WINDOW_CHUNKS)
                        tmp[r*WINDOW_CHUNKS+c] = sh_store[orow*WINDOW_CHUNKS+ocol];
                    else
                        tmp[r*WINDOW_CHUNKS+c] = '0;
                end
            end
            sh_store = tmp;
            sh_cx = wrap8(sh_cx + sx);
            sh_cy = wrap8(sh_cy + sy);
            px = wrap8(cx - sh_cx) + HALF;
            py = wrap8(cy - sh_cy) + HALF;
        end
        return py * WINDOW_CHUNKS + px;
    endfunction

    function automatic void pixel_addr(input int x, input int y,
                                       output int cx, output int cy, output int b);
        int ly;
        cx = wrap8(fdiv8(x));
        if (y > 0) begin
            cy = wrap8(fdiv8(y) + 1);
            ly = 7 - mod8(y - 1);
        end else begin
            cy = wrap8(fdiv8(y));
            ly = mod8(y);
        end
        b = ly * 8 + mod8(x);
    endfunction

    function automatic void put_pixel(input int x, input int y, input logic v);
        int cx, cy, b, idx;
        logic [63:0] w;
        pixel_addr(x, y, cx, cy, b);
        idx = bring_in(cx, cy);
        w = sh_store[idx];
        if (w[b] == v) return;
        w[b] = v;
        sh_store[idx] = w;
        if (cx != pend_x || cy != pend_y) push_note(pend_x, pend_y, pend_word);
        pend_x = cx;
        pend_y = cy;
        pend_word = w;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int clip_len(input int d, input longint unsigned ratio);
        longint unsigned mag;
        mag = (longint'(d < 0 ? -d : d) * ratio) >> 16;
        return d < 0 ? -int'(mag) : int'(mag);
    endfunction

    function automatic void clear_ray(input int x0, input int y0, input int tx, input int ty,
                                      input int lim_in);
        int lim, ddx, ddy, d2, l2, x1, y1, dx, dy, sx, sy, err, e2;
        longint unsigned r, ratio;
        lim = lim_in > MAX_RAY ? MAX_RAY : lim_in;
        ddx = tx - x0;
        ddy = ty - y0;
        d2 = ddx * ddx + ddy * ddy;
        l2 = lim * lim;
        x1 = tx;
        y1 = ty;
        if (d2 > l2) begin
            r = int_sqrt(longint'(d2) << 32);
            ratio = (longint'(lim) << 32) / r;
            x1 = x0 + clip_len(ddx, ratio);
            y1 = y0 + clip_len(ddy, ratio);
        end
        dx = x1 > x0 ? x1 - x0 : x0 - x1;
        dy = -(y1 > y0 ? y1 - y0 : y0 - y1);
        sx = x0 < x1 ? 1 : -1;
        sy = y0 < y1 ? 1 : -1;
        err = dx + dy;
        for (int g = 0; g < 4096; g++) begin
            put_pixel(x0, y0, 1'b0);
            if (x0 == x1 && y0 == y1) break;
            e2 = 2 * err;
            if (e2 >= dy) begin err += dy; x0 += sx; end
            if (e2 <= dx) begin err += dx; y0 += sy; end
        end
        if (d2 <= l2) put_pixel(tx, ty, 1'b1);
    endfunction

    function automatic void map_reset();
        foreach (sh_store[i]) sh_store[i] = '0;
        sh_cx = 0;
        sh_cy = 0;
        pend_x = 0;
        pend_y = 0;
        pend_word = '0;
    endfunction

    // works out every result of one accepted transaction
    function automatic void predict_map_op(input map_op_t op);
        map_rsp_t    rsp;
        logic [63:0] data;
        logic        rbit;
        int          cx, cy, b, idx;
        data = '0;
        rbit = 1'b0;
        note_x.delete();
        note_y.delete();
        note_w.delete();
        case (op.func)
            FN_RD_PIX: begin
                pixel_addr(int'(op.pos_x), int'(op.pos_y), cx, cy, b);
                idx = bring_in(cx, cy);
                rbit = sh_store[idx][b];
            end
            FN_WR_PIX: put_pixel(int'(op.pos_x), int'(op.pos_y), op.pixel_bit);
            FN_RD_CHK: data = sh_store[bring_in(wrap8(op.pos_x), wrap8(op.pos_y))];
            FN_WR_CHK: begin
                cx = wrap8(op.pos_x);
                cy = wrap8(op.pos_y);
                idx = bring_in(cx, cy);
                if (sh_store[idx] != op.chunk_word) begin
                    sh_store[idx] = op.chunk_word;
                    push_note(cx, cy, op.chunk_word);
                    pend_x = cx;
                    pend_y = cy;
                    pend_word = op.chunk_word;
                end
            end
            FN_RAY: clear_ray(int'(op.pos_x), int'(op.pos_y), int'(op.target_x),
                              int'(op.target_y), int'(op.ray_limit));
            FN_CLEAR: map_reset();
            default: ;
        endcase
        for (int k = 0; k < note_x.size(); k++) begin
            rsp = '{KIND_NOTE, note_x[k][7:0], note_y[k][7:0], note_w[k], 1'b0,
                    sh_cx[7:0], sh_cy[7:0], 1'b0};
            rsp_queue.push_back(rsp);
        end
        rsp = '{KIND_DONE, 8'sd0, 8'sd0, data, rbit, sh_cx[7:0], sh_cy[7:0], 1'b1};
        rsp_queue.push_back(rsp);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // sender
    int      send_gap;
    int      calm_left;
    map_op_t cur_op;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            send_gap = 0;
            calm_left = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) predict_map_op(cur_op);
            if (!(in_bus.valid && !in_bus.ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_bus.valid <= 1'b0;
                end else if (op_queue.size() > 0 &&
                             !(op_queue[0].drain && rsp_queue.size() > 0)) begin
                    cur_op = op_queue.pop_front();
                    in_bus.func       <= cur_op.func;
                    in_bus.pos_x      <= cur_op.pos_x;
                    in_bus.pos_y      <= cur_op.pos_y;
                    in_bus.target_x   <= cur_op.target_x;
                    in_bus.target_y   <= cur_op.target_y;
                    in_bus.pixel_bit  <= cur_op.pixel_bit;
                    in_bus.chunk_word <= cur_op.chunk_word;
                    in_bus.ray_limit  <= cur_op.ray_limit;
                    in_bus.valid      <= 1'b1;
                    if (calm_left > 0) begin
                        calm_left--;
                        send_gap = 0;
                    end else begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(5, 15);
                    end
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    map_rsp_t got, want;
    int       stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got = '{out_bus.kind, out_bus.note_chunk_x, out_bus.note_chunk_y,
                        out_bus.note_data, out_bus.read_bit, out_bus.center_x,
                        out_bus.center_y, out_bus.last};
                if (rsp_queue.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result transaction %p", $time, got);
                end else begin
                    want = rsp_queue.pop_front();
                    if (got.kind !== want.kind || got.chunk_x !== want.chunk_x ||
                        got.chunk_y !== want.chunk_y || got.data !== want.data ||
                        got.read_bit !== want.read_bit || got.center_x !== want.center_x ||
                        got.center_y !== want.center_y || got.last !== want.last) begin
                        err_cnt++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                out_bus.ready <= (stall_left == 0) || ($urandom_range(0, 1) == 1);
            end
        end
    end

    function automatic int clampc(input int v);
        return v < -1016 ? -1016 : (v > 1015 ? 1015 : v);
    endfunction

    function automatic void add_op(input logic [2:0] f, input int x, input int y,
                                   input int tx, input int ty, input logic pb,
                                   input logic [63:0] w, input int lim, input bit drain);
        map_op_t op;
        op.func       = f;
        op.pos_x      = 11'(clampc(x));
        op.pos_y      = 11'(clampc(y));
        op.target_x   = 11'(clampc(tx));
        op.target_y   = 11'(clampc(ty));
        op.pixel_bit  = pb;
        op.chunk_word = w;
        op.ray_limit  = 7'(lim);
        op.drain      = drain;
        op_queue.push_back(op);
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic void build_stimulus();
        int fx, fy, x, y, r;
        // directed part
        add_op(FN_RD_PIX, 0, 0, 0, 0, 0, 0, 0, 0);
        add_op(FN_WR_PIX, 0, 0, 0, 0, 1, 0, 0, 0);
        add_op(FN_WR_PIX, 0, 0, 0, 0, 1, 0, 0, 0);       // same value, no change
        add_op(FN_WR_PIX, 5, 1, 0, 0, 1, 0, 0, 0);       // y above zero maps one chunk up
        add_op(FN_WR_PIX, 5, 8, 0, 0, 1, 0, 0, 0);
        add_op(FN_WR_PIX, -1, -9, 0, 0, 1, 0, 0, 0);
        add_op(FN_RD_PIX, 5, 1, 0, 0, 0, 0, 0, 0);
        add_op(FN_RD_CHK, 0, 1, 0, 0, 0, 0, 0, 0);
        add_op(FN_WR_CHK, 3, -2, 0, 0, 0, '1, 0, 0);
        add_op(FN_WR_CHK, 3, -2, 0, 0, 0, '1, 0, 0);     // unchanged word
        add_op(FN_WR_CHK, -1016, 1015, 0, 0, 0, 64'h8000_0000_0000_0001, 0, 0);
        add_op(FN_RD_CHK, -1016, 1015, 0, 0, 0, 0, 0, 0);
        add_op(FN_WR_PIX, 1015, 1015, 0, 0, 1, 0, 0, 0);  // far scroll
        add_op(FN_WR_PIX, -1016, -1016, 0, 0, 1, 0, 0, 0);
        add_op(FN_RD_PIX, -1016, -1016, 0, 0, 0, 0, 0, 0);
        add_op(FN_RAY, -1000, -1000, -990, -995, 0, 0, 127, 0); // obstacle within limit
        add_op(FN_RAY, -1000, -1000, -1000, -1000, 0, 0, 0, 0);  // zero length, limit zero
        add_op(FN_RAY, -1016, -1016, 1015, 1015, 0, 0, 127, 0); // clipped at the limit
        add_op(FN_RAY, 20, 20, -100, 60, 0, 0, 30, 0);
        add_op(FN_RAY, 0, 0, 40, -3, 0, 0, 0, 0);
        add_op(FN_SPARE6, 7, 7, 0, 0, 1, '1, 127, 0);
        add_op(FN_SPARE7, -7, -7, 0, 0, 1, '1, 127, 0);
        add_op(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        add_op(FN_RD_CHK, 3, -2, 0, 0, 0, 0, 0, 1);
        // random part: a roving focus keeps accesses local so data is reread
        fx = 0;
        fy = 0;
        for (int i = 0; i < 106; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                fx = $urandom_range(0, 2031) - 1016;
                fy = $urandom_range(0, 2031) - 1016;
            end else begin
                fx = clampc(fx + $urandom_range(0, 80) - 40);
                fy = clampc(fy + $urandom_range(0, 80) - 40);
            end
            x = fx + $urandom_range(0, 40) - 20;
            y = fy + $urandom_range(0, 40) - 20;
            r = $urandom_range(0, 99);
            if (r < 25)
                add_op(FN_WR_PIX, x, y, 0, 0, $urandom_range(0, 1), 0, 0, i == 60);
            else if (r < 45)
                add_op(FN_RD_PIX, x, y, 0, 0, 0, 0, 0, i == 60);
            else if (r < 55)
                add_op(FN_WR_CHK, fdiv8(x), fdiv8(y), 0, 0, 0, rand_word(), 0, i == 60);
            else if (r < 63)
                add_op(FN_RD_CHK, fdiv8(x) + $urandom_range(0, 4) - 2, fdiv8(y), 0, 0, 0, 0,
                       0, i == 60);
            else if (r < 93)
                add_op(FN_RAY, x, y, x + $urandom_range(0, 300) - 150,
                       y + $urandom_range(0, 300) - 150, 0, 0, $urandom_range(0, 127),
                       i == 60);
            else if (r < 96)
                add_op(FN_RAY, $urandom_range(0, 2031) - 1016, $urandom_range(0, 2031) - 1016,
                       $urandom_range(0, 2031) - 1016, $urandom_range(0, 2031) - 1016,
                       0, 0, $urandom_range(0, 127), i == 60);
            else if (r < 98)
                add_op(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, i == 60);
            else
                add_op($urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7,
                       $urandom_range(0, 2031) - 1016, $urandom_range(0, 2031) - 1016,
                       0, 0, 1, rand_word(), 127, i == 60);
        end
    endfunction

    initial begin
        err_cnt = 0;
        map_reset();
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.func       = FN_RD_PIX;
        in_bus.pos_x      = '0;
        in_bus.pos_y      = '0;
        in_bus.target_x   = '0;
        in_bus.target_y   = '0;
        in_bus.pixel_bit  = 1'b0;
        in_bus.chunk_word = '0;
        in_bus.ray_limit  = '0;
        out_bus.ready     = 1'b0;
        build_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (op_queue.size() == 0 && !in_bus.valid && rsp_queue.size() == 0);
        // leave room for a stray transaction after the last completion
        repeat (600) @(posedge i_clk);
        if (err_cnt == 0)
            $display("** scrolling_occupancy_chunk_map_core: PASSED **");
        else
            $display("** scrolling_occupancy_chunk_map_core: FAILED **");
        $finish;
    end

    initial begin
        #200ms;
        $display("%0t: timeout, %0d transactions still expected", $time, rsp_queue.size());
        $display("** scrolling_occupancy_chunk_map_core: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
sv/socm_pkg.sv
sv/socm_ifs.sv
sv/socm_ram.sv
sv/socm_clip.sv
sv/scrolling_occupancy_chunk_map_core.sv
verif/scrolling_occupancy_chunk_map_core_tb.sv
